FILE: sv/dtcv_pkg.sv
`default_nettype none
package dtcv_pkg;
   localparam int DELAY_DEPTH_DEF  = 2048;
   localparam int SAMPLE_WIDTH_DEF = 24;

   localparam int CFG_WIDTH = 17;
   localparam int CFG_INDEX_WIDTH = 2;
   localparam logic [CFG_INDEX_WIDTH-1:0] REG_TARGET = 2'd0;
   localparam logic [CFG_INDEX_WIDTH-1:0] REG_WET    = 2'd1;
   localparam logic [CFG_INDEX_WIDTH-1:0] REG_SCALE  = 2'd2;

   localparam logic [16:0] ONE_Q16     = 17'd65536;
   localparam logic [16:0] TARGET_RST  = 17'd27591;
   localparam logic [16:0] WET_RST     = 17'd65536;
   localparam logic [10:0] SCALE_RST   = 11'd256;
   localparam logic [10:0] SCALE_MIN   = 11'd256;
   localparam logic [10:0] SCALE_MAX   = 11'd1024;
   localparam logic [32:0] CTRL_RST    = 33'd1808181232;
   localparam logic [24:0] SMOOTH_KEEP = 25'd16772183;
   localparam logic [12:0] SMOOTH_K    = 13'd5033;
   localparam logic [6:0]  A_GAIN      = 7'd77;
   localparam logic [17:0] A_BIAS      = 18'd209715;
   localparam logic [17:0] B_GAIN      = 18'd252314;
   localparam logic [21:0] B_BIAS      = 22'd2686976;
   localparam logic [12:0] WT_A_OUTER  = 13'd7021;
   localparam logic [14:0] WT_A_MID    = 15'd17957;
   localparam logic [15:0] WT_B_OUTER  = 16'd37842;
   localparam logic [15:0] WT_B_MID    = 16'd41222;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CTRL, ST_SQUARE, ST_AQ, ST_DELAY, ST_WRITE, ST_TAP0, ST_TAP1,
      ST_TAP2, ST_TAP3, ST_TAP4, ST_TAP5, ST_DRAIN, ST_MIX, ST_OUT
   } state_type;

   typedef struct packed {
      logic load;    // capture the input item
      logic ctrl;    // update smoothed control
      logic square;  // square of the rounded control
      logic aq;      // delay A before scaling
      logic delay;   // second delay product
      logic write;   // store the sample
      logic rd;      // issue a tap read
      logic [2:0] tap;
      logic acc;     // accumulate the read data from the previous cycle
      logic mix;     // wet/dry mix and output register load
   } cmd_type;
endpackage
`default_nettype wire

FILE: sv/dtcv_ctrl.sv
`default_nettype none
module dtcv_ctrl import dtcv_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic in_valid,
   output logic      in_ready,
   input  wire logic out_busy,
   output cmd_type   cmd
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      in_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CTRL;
            end
         end
         ST_CTRL: begin cmd.ctrl = 1'b1; state_in = ST_SQUARE; end
         ST_SQUARE: begin cmd.square = 1'b1; state_in = ST_AQ; end
         ST_AQ: begin cmd.aq = 1'b1; state_in = ST_DELAY; end
         ST_DELAY: begin cmd.delay = 1'b1; state_in = ST_WRITE; end
         ST_WRITE: begin cmd.write = 1'b1; state_in = ST_TAP0; end
         ST_TAP0: begin cmd.rd = 1'b1; cmd.tap = 3'd0; state_in = ST_TAP1; end
         ST_TAP1: begin
            cmd.rd = 1'b1; cmd.tap = 3'd1; cmd.acc = 1'b1; state_in = ST_TAP2;
         end
         ST_TAP2: begin
            cmd.rd = 1'b1; cmd.tap = 3'd2; cmd.acc = 1'b1; state_in = ST_TAP3;
         end
         ST_TAP3: begin
            cmd.rd = 1'b1; cmd.tap = 3'd3; cmd.acc = 1'b1; state_in = ST_TAP4;
         end
         ST_TAP4: begin
            cmd.rd = 1'b1; cmd.tap = 3'd4; cmd.acc = 1'b1; state_in = ST_TAP5;
         end
         ST_TAP5: begin
            cmd.rd = 1'b1; cmd.tap = 3'd5; cmd.acc = 1'b1; state_in = ST_DRAIN;
         end
         ST_DRAIN: begin cmd.acc = 1'b1; state_in = ST_MIX; end
         ST_MIX: begin
            if (!out_busy) begin
               cmd.mix = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule
`default_nettype wire

FILE: sv/dtcv_datapath.sv
`default_nettype none
module dtcv_datapath import dtcv_pkg::*; #(
   parameter int DELAY_DEPTH  = DELAY_DEPTH_DEF,
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire cmd_type                 cmd,
   input  wire logic [SAMPLE_WIDTH-1:0] sample_in,
   input  wire logic                    block_end,
   input  wire logic [16:0]             target_q16,
   input  wire logic [16:0]             wet_q16,
   input  wire logic [10:0]             rate_scale_q8,
   output logic                         out_valid,
   input  wire logic                    out_ready,
   output logic [SAMPLE_WIDTH-1:0]      sample_out,
   output logic                         block_end_out
);
   localparam int AW = $clog2(DELAY_DEPTH);
   localparam int SW = SAMPLE_WIDTH;
   localparam int ACCW = SW + 20;
   localparam int MW = ACCW + 8;

   // Clear sweep: after reset, zeros are written into every entry of the store.
   logic [AW:0] clr_ff;
   logic clearing;
   assign clearing = !clr_ff[AW];

   logic signed [SW-1:0] mem [DELAY_DEPTH];
   logic signed [SW-1:0] rdata_ff;
   logic signed [SW-1:0] x_ff;
   logic be_ff;
   logic [AW-1:0] wpos_ff;
   logic [32:0] ctrl_ff;
   logic [33:0] sq_ff;
   logic [22:0] aq_ff;
   logic [24:0] bq_ff;
   logic [AW+1:0] da_ff, db_ff;
   logic [AW-1:0] raddr;
   logic signed [ACCW-1:0] acc_ff;
   logic [2:0] tap_ff;
   logic out_valid_ff;
   logic [SW-1:0] y_ff;
   logic be_out_ff;

   logic [16:0] tgt, wet;
   logic [10:0] scale;
   assign tgt = (target_q16 > ONE_Q16) ? ONE_Q16 : target_q16;
   assign wet = (wet_q16 > ONE_Q16) ? ONE_Q16 : wet_q16;
   always_comb begin
      scale = rate_scale_q8;
      if (scale < SCALE_MIN) scale = SCALE_MIN;
      if (scale > SCALE_MAX) scale = SCALE_MAX;
   end

   // Smoothing update, square and delay A, one step per cycle.
   logic [58:0] c_prod;
   logic [32:0] c_next;
   logic [16:0] s_q16;
   logic [33:0] sq;
   logic [40:0] sq77;
   logic [22:0] aq_next;
   assign c_prod = ctrl_ff * SMOOTH_KEEP + {tgt, 16'd0} * SMOOTH_K + 59'd8388608;
   assign c_next = c_prod[56:24];
   assign s_q16 = 17'((ctrl_ff + 33'd32768) >> 16);
   assign sq = s_q16 * s_q16;
   assign sq77 = sq_ff * A_GAIN + 41'd32768;
   assign aq_next = 23'(sq77[40:16]) + 23'(A_BIAS);

   logic [41:0] aqb;
   logic [24:0] bq_next;
   assign aqb = aq_ff * B_GAIN + 42'd32768;
   assign bq_next = 25'(aqb[41:16]) + 25'(B_BIAS);
   logic [34:0] dap, dbp;
   assign dap = aq_ff * scale;
   assign dbp = bq_ff * scale;

   logic [2:0] wa;
   logic [4:0] wb;
   assign wa = 3'(scale >> 8);
   assign wb = 5'((14'd7 * scale) >> 8);

   always_comb begin
      logic [AW+7:0] off;
      case (cmd.tap)
         3'd0: off = (AW+8)'(da_ff);
         3'd1: off = (AW+8)'(da_ff) + (AW+8)'(wa);
         3'd2: off = (AW+8)'(da_ff) + (AW+8)'({wa, 1'b0});
         3'd3: off = (AW+8)'(db_ff);
         3'd4: off = (AW+8)'(db_ff) + (AW+8)'(wb);
         3'd5: off = (AW+8)'(db_ff) + (AW+8)'({wb, 1'b0});
         default: off = '0;
      endcase
      raddr = AW'(((AW+8)'(wpos_ff) + off) % DELAY_DEPTH);
   end

   always_ff @(posedge clock) begin
      if (clearing) mem[clr_ff[AW-1:0]] <= '0;
      else if (cmd.write) mem[wpos_ff] <= x_ff;
      if (cmd.rd) rdata_ff <= mem[raddr];
   end

   logic signed [17:0] wt;
   always_comb begin
      case (tap_ff)
         3'd0, 3'd2: wt = 18'(WT_A_OUTER);
         3'd1:       wt = 18'(WT_A_MID);
         3'd3, 3'd5: wt = -18'(WT_B_OUTER);
         3'd4:       wt = -18'(WT_B_MID);
         default:    wt = '0;
      endcase
   end

   logic signed [ACCW-1:0] q;
   logic signed [MW+17:0] m;
   logic signed [MW-6:0] y;
   logic signed [SW-1:0] y_sat;
   localparam logic signed [MW-6:0] HI = (MW-5)'((64'sd1 <<< (SW-1)) - 1);
   localparam logic signed [MW-6:0] LO = -HI - 1;
   assign q = (acc_ff + ACCW'(512)) >>> 10;
   assign m = (MW+18)'(q) * $signed({1'b0, wet}) +
              (MW+18)'(x_ff) * $signed({1'b0, 17'(ONE_Q16 - wet), 8'd0})
              + (MW+18)'(64'sd1 <<< 23);
   assign y = (MW-5)'(m >>> 24);
   assign y_sat = (y > HI) ? SW'(HI) : (y < LO) ? SW'(LO) : SW'(y);

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
         wpos_ff <= '0;
         ctrl_ff <= CTRL_RST;
         out_valid_ff <= 1'b0;
      end else begin
         if (clearing) clr_ff <= clr_ff + 1'b1;
         if (cmd.ctrl) ctrl_ff <= c_next;
         // The taps are read relative to the position just written, so the
         // write position steps down only once the item is finished.
         if (cmd.mix) wpos_ff <= (wpos_ff == '0) ? AW'(DELAY_DEPTH - 1) : wpos_ff - 1'b1;
         if (cmd.mix) out_valid_ff <= 1'b1;
         else if (out_ready) out_valid_ff <= 1'b0;
      end
      if (cmd.load) begin
         x_ff <= sample_in;
         be_ff <= block_end;
      end
      if (cmd.square) sq_ff <= sq;
      if (cmd.aq) aq_ff <= aq_next;
      if (cmd.delay) begin
         bq_ff <= bq_next;
         da_ff <= (AW+2)'(dap >> 24);
      end
      if (cmd.write) begin
         db_ff <= (AW+2)'(dbp >> 24);
         acc_ff <= ACCW'(x_ff) <<< 16;
      end
      if (cmd.rd) tap_ff <= cmd.tap;
      if (cmd.acc) acc_ff <= acc_ff + ACCW'(rdata_ff * wt);
      if (cmd.mix) begin
         y_ff <= y_sat;
         be_out_ff <= be_ff;
      end
   end

   // mix waits while the previous result is still pending
   assign out_valid = out_valid_ff;
   assign sample_out = y_ff;
   assign block_end_out = be_out_ff;
endmodule
`default_nettype wire

FILE: sv/dual_tap_comb_voice_filter_core.sv
`default_nettype none
// Dual-tap comb voice filter. Each item carries one signed audio sample; it
// is written into a circular delay store, six taps around two smoothed
// delays are read back one per cycle from the single store read port and
// weighted, and the result is mixed with the dry sample and saturated.
// After an item is accepted the steps run in order: smoothing update,
// square and delay A, then the second delay, the store write, six
// sequential store reads, a drain of the last read and the mix, which
// waits while the previous result is still pending. The next item is taken
// the cycle after the result registers, so a new item is not taken before
// the previous one is mixed. After reset a clearing sweep zeroes the store;
// no item is taken during it. Configuration writes are taken at any time.
module dual_tap_comb_voice_filter_core import dtcv_pkg::*; #(
   parameter int DELAY_DEPTH  = DELAY_DEPTH_DEF,
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic      req_tready,
   // sample_in
   input  wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0] req_tdata,
   input  wire logic req_tlast,
   output logic      rsp_tvalid,
   input  wire logic rsp_tready,
   // sample_out
   output logic [((SAMPLE_WIDTH+7)/8)*8-1:0] rsp_tdata,
   output logic      rsp_tlast,
   input  wire logic csr_we,
   input  wire logic [CFG_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CFG_WIDTH-1:0] csr_wdata
);
   localparam int AW = $clog2(DELAY_DEPTH);
   localparam int TW = ((SAMPLE_WIDTH+7)/8)*8;

   logic [16:0] target_ff, wet_ff;
   logic [10:0] scale_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= TARGET_RST;
         wet_ff <= WET_RST;
         scale_ff <= SCALE_RST;
      end else if (csr_we) begin
         case (csr_index)
            REG_TARGET: target_ff <= csr_wdata;
            REG_WET:    wet_ff <= csr_wdata;
            REG_SCALE:  scale_ff <= csr_wdata[10:0];
            default: ;
         endcase
      end
   end

   // Hold off input during the clearing sweep after reset.
   logic [AW:0] sweep_ff;
   always_ff @(posedge clock) begin
      if (reset) sweep_ff <= '0;
      else if (!sweep_ff[AW]) sweep_ff <= sweep_ff + 1'b1;
   end

   cmd_type cmd;
   logic ctl_ready;
   logic [SAMPLE_WIDTH-1:0] y;

   dtcv_ctrl u_ctrl (
      .clock(clock), .reset(reset), .in_valid(req_tvalid && sweep_ff[AW]),
      .in_ready(ctl_ready), .out_busy(rsp_tvalid && !rsp_tready), .cmd(cmd)
   );
   assign req_tready = ctl_ready && sweep_ff[AW];

   dtcv_datapath #(.DELAY_DEPTH(DELAY_DEPTH), .SAMPLE_WIDTH(SAMPLE_WIDTH)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd),
      .sample_in(req_tdata[SAMPLE_WIDTH-1:0]), .block_end(req_tlast),
      .target_q16(target_ff), .wet_q16(wet_ff), .rate_scale_q8(scale_ff),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .sample_out(y), .block_end_out(rsp_tlast)
   );
   assign rsp_tdata = TW'(y);

   a_no_accept_in_sweep: assert property (@(posedge clock) disable iff (reset)
      !sweep_ff[AW] |-> !req_tready) else $error("accepted during clear");
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.ctrl, cmd.square, cmd.aq, cmd.delay, cmd.write,
                cmd.mix}))
      else $error("overlapping commands");
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> !req_tready) else $error("second item taken");
endmodule
`default_nettype wire
